// File: hw/rtl/slt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg: shared constants for the sorted list table
// Table size, field widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package slt_pkg;

   // table size and derived widths
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);

   // word field widths
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int STORED_W = 5;

   // operation codes (the unused code decodes as a list)
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage : slt_pkg
`default_nettype wire

// File: hw/rtl/sorted_list_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_table_core: bounded table of signed words in ascending order
// Insert, delete-one-copy and list, run by a small sequencer over a single
// entry memory with one compare unit; one memory element is visited a cycle.
// ----------------------------------------------------------------------------
// Operation: an insert into a nonempty table walks down from the top, shifting
//   words up until it finds the slot; a delete scans up to the value, then
//   shifts the words above it down; a list reads out every word; full, empty
//   cases finish in the accept cycle. Each result is registered before it shows.
// Items: one item at a time; start is taken only while the block is not busy.
// Reset clears the count and the sequencer; the entry memory is not cleared.
module sorted_list_table_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [slt_pkg::OP_W-1:0]      req_op,
   input  wire logic signed [slt_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [slt_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [slt_pkg::VALUE_W-1:0] rsp_entry,
   output logic [slt_pkg::STORED_W-1:0]       rsp_stored_count,
   output logic                               rsp_last
);
   import slt_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS_CMP = 3'd1;
   localparam logic [2:0] S_INS_PUT = 3'd2;
   localparam logic [2:0] S_DEL_SRC = 3'd3;
   localparam logic [2:0] S_DEL_SHF = 3'd4;
   localparam logic [2:0] S_LST_OUT = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [VALUE_W-1:0] val_ff, val_in;

   // entry memory: one write and one registered read per cycle
   logic [VALUE_W-1:0] entries_mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;

   // result register
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_entry_ff, rsp_entry_in;
   logic                rsp_last_ff, rsp_last_in;

   // shared compare unit
   logic rd_less;
   logic rd_equal;
   logic accept;

   assign accept   = start && (state_ff == S_IDLE);
   assign rd_less  = $signed(rd_data_ff) < $signed(val_ff);
   assign rd_equal = rd_data_ff == val_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_entry_in  = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in = req_value;
               idx_in = '0;
               rd_addr = '0;
               unique case (req_op)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = req_value;
                        count_in      = CNT_W'(1);
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_DONE;
                     end else begin
                        // walk down from the top, shifting words not less than the value up
                        idx_in   = count_ff;
                        rd_addr  = IDX_W'(count_ff - CNT_W'(1));
                        state_in = S_INS_CMP;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        state_in = S_DEL_SRC;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_LST_OUT;
                     end
                  end
               endcase
            end
         end
         S_INS_CMP: begin
            // rd_data holds entry idx-1
            wr_en = 1'b1;
            if (rd_less) begin
               wr_data       = val_ff;
               count_in      = count_ff + CNT_W'(1);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               wr_data = rd_data_ff;
               idx_in  = idx_ff - CNT_W'(1);
               if (idx_ff == CNT_W'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  rd_addr = IDX_W'(idx_ff - CNT_W'(2));
               end
            end
         end
         S_INS_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data       = val_ff;
            count_in      = count_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_DEL_SRC: begin
            // rd_data holds entry idx; next entry read speculatively
            rd_addr = IDX_W'(idx_ff + CNT_W'(1));
            if (rd_equal) begin
               if (idx_ff + CNT_W'(1) < count_ff) begin
                  state_in = S_DEL_SHF;
               end else begin
                  count_in      = count_ff - CNT_W'(1);
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (idx_ff + CNT_W'(1) >= count_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_NOTFOUND;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         S_DEL_SHF: begin
            // rd_data holds entry idx+1, moved down into idx
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_ff + CNT_W'(1);
            rd_addr = IDX_W'(idx_ff + CNT_W'(2));
            if (idx_ff + CNT_W'(2) >= count_ff) begin
               count_in      = count_ff - CNT_W'(1);
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_LST_OUT: begin
            // one stored word per cycle
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_ENTRY;
            rsp_entry_in  = rd_data_ff;
            rsp_last_in   = (idx_ff + CNT_W'(1)) == count_ff;
            idx_in        = idx_ff + CNT_W'(1);
            rd_addr       = IDX_W'(idx_ff + CNT_W'(1));
            if (rsp_last_in) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // entry memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entries_mem[rd_addr];
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry        = rsp_entry_ff;
   assign rsp_stored_count = STORED_W'(count_ff);
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // the table never holds more than its capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   // an accepted item either answers next cycle or keeps the block busy
   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted item dropped");

   // a word that is not the final one comes from a list still running
   a_mid_list_busy : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final word while idle");

   // only list entries may be followed by more words
   a_single_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_ENTRY)) |-> rsp_last)
      else $error("non-list result not final");
`endif

endmodule : sorted_list_table_core
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sorted_list_table_core
// Drives insert, delete and list words in random bursts, keeps a shadow copy
// of the ordered table, and compares every result word with the shadow's
// prediction in order of arrival.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slt_pkg::*;

   // the decoder treats the spare op code as a list
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int NUM_RANDOM  = 345;
   localparam int IDLE_LIMIT  = 1000;
   localparam int DRAIN_WAIT  = 40;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] entry;
      logic [STORED_W-1:0]       stored;
      logic                      last;
   } rsp_word_type;

   // shadow table plus the queue of result words it has predicted
   class slt_shadow_type;
      logic signed [VALUE_W-1:0] held_vals[$];
      rsp_word_type              due_words[$];
      int                        errors = 0;

      function void push_word(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] ent,
                              logic lst);
         rsp_word_type w;
         w.status = st;
         w.entry  = ent;
         w.stored = STORED_W'(held_vals.size());
         w.last   = lst;
         due_words.push_back(w);
      endfunction

      // update the table for one accepted word and queue its results
      function void apply_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val);
         int pos;
         pos = 0;
         case (op)
            OP_INSERT: begin
               if (held_vals.size() >= CAPACITY) begin
                  push_word(ST_FULL, '0, 1'b1);
               end else begin
                  // lands ahead of any equal copies
                  while (pos < held_vals.size() && held_vals[pos] < val) pos++;
                  held_vals.insert(pos, val);
                  push_word(ST_DONE, '0, 1'b1);
               end
            end
            OP_DELETE: begin
               while (pos < held_vals.size() && held_vals[pos] != val) pos++;
               if (pos >= held_vals.size()) begin
                  push_word(ST_NOTFOUND, '0, 1'b1);
               end else begin
                  held_vals.delete(pos);
                  push_word(ST_DONE, '0, 1'b1);
               end
            end
            default: begin
               if (held_vals.size() == 0) begin
                  push_word(ST_EMPTY, '0, 1'b1);
               end else begin
                  foreach (held_vals[i])
                     push_word(ST_ENTRY, held_vals[i], i == held_vals.size() - 1);
               end
            end
         endcase
      endfunction

      // compare one result word with the oldest prediction
      function void match_word(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] ent,
                               logic [STORED_W-1:0] cnt, logic lst);
         rsp_word_type want;
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word: status=%0d entry=%0d count=%0d last=%0b",
                     $time, st, ent, cnt, lst);
            errors++;
            return;
         end
         want = due_words.pop_front();
         if (st !== want.status || ent !== want.entry || cnt !== want.stored
             || lst !== want.last) begin
            $display("%0t: word mismatch: expected status=%0d entry=%0d count=%0d last=%0b",
                     $time, want.status, want.entry, want.stored, want.last);
            $display("%0t:                actual   status=%0d entry=%0d count=%0d last=%0b",
                     $time, st, ent, cnt, lst);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_op = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_strobe;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_entry;
   logic [STORED_W-1:0]       rsp_stored_count;
   logic                      rsp_last;

   slt_shadow_type sb = new();
   int        burst_left = 0;
   int        idle_cycles = 0;

   sorted_list_table_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_entry        (rsp_entry),
      .rsp_stored_count (rsp_stored_count),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.match_word(rsp_status, rsp_entry, rsp_stored_count, rsp_last);
   end

   // watchdog: cycles with neither an accepted word nor a result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("** sorted_list_table_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // half the time a small pool so duplicates and delete hits are common
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return VALUE_W'($signed($urandom_range(0, 15)) - 8);
         5: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // present one word, holding it until the block takes it
   task automatic issue(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      start     <= 1'b1;
      req_op    <= op;
      req_value <= val;
      do @(posedge clock); while (busy);
      sb.apply_op(op, val);
   endtask

   initial begin
      logic       filling;
      int         roll;
      logic [OP_W-1:0] op;
      logic signed [VALUE_W-1:0] val;

      filling = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, fill to full
      issue(OP_LIST, '0);
      issue(OP_SPARE, 32'sh1234_5678);
      issue(OP_DELETE, 32'sd7);
      issue(OP_INSERT, VAL_MAX);
      issue(OP_INSERT, VAL_MIN);
      issue(OP_INSERT, '0);
      issue(OP_INSERT, '0);
      issue(OP_INSERT, -1);
      issue(OP_INSERT, 32'sd1);
      issue(OP_INSERT, 32'sh5555_5555);
      issue(OP_INSERT, 32'shAAAA_AAAA);
      issue(OP_LIST, 32'shFFFF_FFFF);
      issue(OP_DELETE, '0);
      issue(OP_DELETE, 32'sd12345);
      repeat (9) issue(OP_INSERT, $urandom);
      issue(OP_INSERT, VAL_MAX);
      issue(OP_SPARE, '0);

      // random: sweep the fill level up and down
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (sb.held_vals.size() >= CAPACITY) filling = 1'b0;
         if (sb.held_vals.size() == 0)        filling = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 14) begin
            op  = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_LIST;
            val = $urandom;
         end else if (filling ? (roll < 70) : (roll < 38)) begin
            op  = OP_INSERT;
            val = pick_value();
         end else begin
            op = OP_DELETE;
            if (sb.held_vals.size() != 0 && $urandom_range(0, 3) != 0)
               val = sb.held_vals[$urandom_range(0, sb.held_vals.size() - 1)];
            else
               val = pick_value();
         end
         issue(op, val);
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0 && sb.due_words.size() == 0) begin
         $display("** sorted_list_table_core: PASSED **");
      end else begin
         $display("** sorted_list_table_core: FAILED **");
      end
      $finish;
   end

endmodule : tb_top
`default_nettype wire

// File: filelist.f
hw/rtl/slt_pkg.sv
hw/rtl/sorted_list_table_core.sv
sim/tb_top.sv
